@@ design/psb_pkg.sv @@
// Shared types and constants of the phase-shift beamformer.
// Used by the controller, the datapath and the top level; no dependencies.
package psb_pkg;

  // Default array geometry.
  localparam int NumDirsDef = 64;
  localparam int NumMicsDef = 16;

  // Field widths of the item ports.
  localparam int DirFieldW = 6;
  localparam int MicFieldW = 4;
  localparam int SampleW   = 16;
  localparam int WeightW   = 16;
  localparam int ProdW     = SampleW + WeightW;
  localparam int SumW      = 36;

  // Configuration port.
  localparam int              ApbAddrW    = 3;
  localparam int              ApbDataW    = 32;
  localparam int              CfgW        = 7;
  localparam logic [CfgW-1:0] CfgDirsRst  = 7'd64;
  // Register index, taken from the word address bit of paddr.
  localparam logic            RegIdxDirs  = 1'b0;

  // Item kind carried on mode.
  localparam logic ModeWeight = 1'b0;
  localparam logic ModeSample = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StSweep,
    StDrain,
    StEmitRd,
    StEmitLd
  } psb_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_weight;
    logic latch_sample;
    logic sweep;
    logic acc_rd;
    logic out_load;
    logic out_last;
    logic clear_acc;
  } psb_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } psb_status_t;

endpackage

@@ design/psb_datapath.sv @@
// Datapath of the beamformer: weight memories, accumulator memory with valid
// bits, the multiply-accumulate pipeline and the output register. Uses psb_pkg.
module psb_datapath #(
  parameter int NUM_DIRS = psb_pkg::NumDirsDef,
  parameter int NUM_MICS = psb_pkg::NumMicsDef,
  localparam int DirW = (NUM_DIRS > 1) ? $clog2(NUM_DIRS) : 1
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  psb_pkg::psb_cmd_t                     cmd_i,
  input  logic [DirW-1:0]                       dir_i,
  output psb_pkg::psb_status_t                  status_o,
  input  logic [psb_pkg::DirFieldW-1:0]         direction_index_i,
  input  logic [psb_pkg::MicFieldW-1:0]         mic_index_i,
  input  logic signed [psb_pkg::WeightW-1:0]    weight_real_i,
  input  logic signed [psb_pkg::WeightW-1:0]    weight_imag_i,
  input  logic signed [psb_pkg::SampleW-1:0]    sample_value_i,
  input  logic                                  out_ready_i,
  output logic                                  out_valid_o,
  output logic [psb_pkg::DirFieldW-1:0]         out_direction_o,
  output logic signed [psb_pkg::SumW-1:0]       sum_real_o,
  output logic signed [psb_pkg::SumW-1:0]       sum_imag_o,
  output logic                                  last_direction_o
);
  import psb_pkg::*;

  localparam int WDepth = NUM_DIRS * NUM_MICS;
  localparam int AddrW  = (WDepth > 1) ? $clog2(WDepth) : 1;

  logic signed [WeightW-1:0] w_re_mem [WDepth];
  logic signed [WeightW-1:0] w_im_mem [WDepth];
  logic signed [SumW-1:0]    acc_re_mem [NUM_DIRS];
  logic signed [SumW-1:0]    acc_im_mem [NUM_DIRS];

  logic [NUM_DIRS-1:0]       acc_vld_bits_q;

  logic [AddrW-1:0]          wr_addr;
  logic [AddrW-1:0]          rd_addr;

  logic signed [SampleW-1:0] sample_q;
  logic [MicFieldW-1:0]      mic_q;

  logic signed [WeightW-1:0] w_re_q;
  logic signed [WeightW-1:0] w_im_q;
  logic signed [SumW-1:0]    acc_re_rd_q;
  logic signed [SumW-1:0]    acc_im_rd_q;
  logic                      acc_vld_rd_q;
  logic signed [SumW-1:0]    acc_re_val;
  logic signed [SumW-1:0]    acc_im_val;

  logic                      s1_valid_q;
  logic [DirW-1:0]           s1_dir_q;
  logic                      s2_valid_q;
  logic [DirW-1:0]           s2_dir_q;
  logic signed [ProdW-1:0]   prod_re_q;
  logic signed [ProdW-1:0]   prod_im_q;
  logic signed [SumW-1:0]    hold_re_q;
  logic signed [SumW-1:0]    hold_im_q;
  logic signed [SumW-1:0]    acc_re_new;
  logic signed [SumW-1:0]    acc_im_new;

  logic                      out_valid_q;
  logic [DirFieldW-1:0]      out_dir_q;
  logic signed [SumW-1:0]    out_re_q;
  logic signed [SumW-1:0]    out_im_q;
  logic                      out_last_q;

  // Weight address is direction times microphone count plus microphone.
  assign wr_addr = AddrW'(direction_index_i) * AddrW'(NUM_MICS) + AddrW'(mic_index_i);
  assign rd_addr = AddrW'(dir_i) * AddrW'(NUM_MICS) + AddrW'(mic_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_weight) begin
      w_re_mem[wr_addr] <= weight_real_i;
      w_im_mem[wr_addr] <= weight_imag_i;
    end
    if (cmd_i.sweep) begin
      w_re_q <= w_re_mem[rd_addr];
      w_im_q <= w_im_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_sample) begin
      sample_q <= sample_value_i;
      mic_q    <= mic_index_i;
    end
  end

  // Accumulator memory: one read port shared by sweep and emit, one write port.
  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      acc_re_mem[s2_dir_q] <= acc_re_new;
      acc_im_mem[s2_dir_q] <= acc_im_new;
    end
    if (cmd_i.acc_rd) begin
      acc_re_rd_q  <= acc_re_mem[dir_i];
      acc_im_rd_q  <= acc_im_mem[dir_i];
      acc_vld_rd_q <= acc_vld_bits_q[dir_i];
    end
  end

  // An entry never written since the last clear reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_vld_bits_q <= '0;
    end else if (cmd_i.clear_acc) begin
      acc_vld_bits_q <= '0;
    end else if (s2_valid_q) begin
      acc_vld_bits_q[s2_dir_q] <= 1'b1;
    end
  end

  assign acc_re_val = acc_vld_rd_q ? acc_re_rd_q : '0;
  assign acc_im_val = acc_vld_rd_q ? acc_im_rd_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.sweep;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_dir_q  <= dir_i;
    s2_dir_q  <= s1_dir_q;
    prod_re_q <= sample_q * w_re_q;
    prod_im_q <= sample_q * w_im_q;
    hold_re_q <= acc_re_val;
    hold_im_q <= acc_im_val;
  end

  // Products are sign-extended; the sum wraps modulo 2^36.
  assign acc_re_new = hold_re_q + SumW'(prod_re_q);
  assign acc_im_new = hold_im_q + SumW'(prod_im_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_dir_q  <= DirFieldW'(dir_i);
      out_re_q   <= acc_re_val;
      out_im_q   <= acc_im_val;
      out_last_q <= cmd_i.out_last;
    end
  end

  assign status_o.pipe_busy = s1_valid_q | s2_valid_q;
  assign status_o.out_free  = ~out_valid_q | out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign out_direction_o  = out_dir_q;
  assign sum_real_o       = out_re_q;
  assign sum_imag_o       = out_im_q;
  assign last_direction_o = out_last_q;

`ifndef SYNTHESIS
  // Sums are emitted only once every accumulator write has landed.
  a_emit_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !s1_valid_q && !s2_valid_q)
    else $error("result loaded while accumulation still in flight");

  // Clearing never races an accumulator write.
  a_clear_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear_acc |-> !s2_valid_q && !cmd_i.sweep)
    else $error("accumulator clear overlaps an update");
`endif

endmodule

@@ design/psb_controller.sv @@
// Controller state machine of the beamformer: input handshake, direction sweep,
// drain and emit sequencing. Drives psb_datapath through psb_pkg command types.
module psb_controller #(
  parameter int NUM_DIRS = psb_pkg::NumDirsDef,
  parameter int NUM_MICS = psb_pkg::NumMicsDef,
  localparam int DirW = (NUM_DIRS > 1) ? $clog2(NUM_DIRS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic [psb_pkg::DirFieldW-1:0] direction_index_i,
  input  logic [psb_pkg::MicFieldW-1:0] mic_index_i,
  input  logic                          last_mic_i,
  input  logic [psb_pkg::CfgW-1:0]      dirs_in_use_i,
  input  psb_pkg::psb_status_t          status_i,
  output psb_pkg::psb_cmd_t             cmd_o,
  output logic [DirW-1:0]               dir_o
);
  import psb_pkg::*;

  psb_state_e      state_q, state_d;
  logic [DirW-1:0] dir_q, dir_d;
  logic            last_q, last_d;
  logic [DirW-1:0] last_idx;
  logic            mic_ok;
  logic            dir_ok;
  logic            accept;

  assign mic_ok     = 32'(mic_index_i) < 32'(NUM_MICS);
  assign dir_ok     = 32'(direction_index_i) < 32'(NUM_DIRS);
  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i & in_ready_o;

  // Index of the final emitted direction, with the register clamped to 1..NUM_DIRS.
  always_comb begin
    priority if (dirs_in_use_i == '0) begin
      last_idx = '0;
    end else if (dirs_in_use_i > CfgW'(NUM_DIRS)) begin
      last_idx = DirW'(NUM_DIRS - 1);
    end else begin
      last_idx = DirW'(dirs_in_use_i - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      dir_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      dir_q   <= dir_d;
      last_q  <= last_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    dir_d      = dir_q;
    last_d     = last_q;
    cmd_o      = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (mode_i == ModeWeight) begin
            cmd_o.wr_weight = dir_ok & mic_ok;
          end else begin
            cmd_o.latch_sample = 1'b1;
            dir_d  = '0;
            last_d = last_mic_i;
            if (mic_ok) begin
              state_d = StSweep;
            end else if (last_mic_i) begin
              state_d = StEmitRd;
            end
          end
        end
      end
      StSweep: begin
        cmd_o.sweep  = 1'b1;
        cmd_o.acc_rd = 1'b1;
        if (dir_q == DirW'(NUM_DIRS - 1)) begin
          state_d = StDrain;
        end else begin
          dir_d = dir_q + 1'b1;
        end
      end
      StDrain: begin
        if (!status_i.pipe_busy) begin
          dir_d   = '0;
          state_d = last_q ? StEmitRd : StIdle;
        end
      end
      StEmitRd: begin
        cmd_o.acc_rd = 1'b1;
        state_d      = StEmitLd;
      end
      StEmitLd: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = (dir_q == last_idx);
          if (dir_q == last_idx) begin
            cmd_o.clear_acc = 1'b1;
            state_d         = StIdle;
          end else begin
            dir_d   = dir_q + 1'b1;
            state_d = StEmitRd;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign dir_o = dir_q;

`ifndef SYNTHESIS
  // The clear of the sums belongs to the final result of a snapshot.
  a_clear_with_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clear_acc |-> cmd_o.out_load && cmd_o.out_last)
    else $error("accumulators cleared outside the final result");

  // A result is loaded only into a free output register.
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> status_i.out_free && state_q == StEmitLd)
    else $error("result loaded over a pending one");

  // A sample that ends a snapshot always leads into emission.
  a_last_leads_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDrain && !status_i.pipe_busy && last_q) |=> state_q == StEmitRd)
    else $error("snapshot end did not start emission");
`endif

endmodule

@@ design/phase_shift_beamformer.sv @@
// Top level of the phase-shift beamformer: configuration register, controller
// and datapath. Depends on psb_pkg, psb_controller and psb_datapath.
//
// Usage. The input channel carries two kinds of item, chosen by mode_i. A weight
// item (mode 0) stores one Q1.15 complex steering weight for a direction and a
// microphone. A sample item (mode 1) carries one real 16-bit microphone sample,
// which is multiplied by every direction's weight for that microphone and added
// into one 36-bit complex sum per direction. The sweep handles one direction per
// cycle through a three-stage read, multiply and accumulate pipeline; the next
// item is taken once the pipeline has drained.
// A sample with last_mic_i set ends the snapshot: after the sweep the block
// emits one result per direction in use (register directions_in_use at
// address 0, reset value 64, clamped to 1..NUM_DIRS), with last_direction_o on
// the final one, and then clears all sums.
// The output register decouples the sides: once the final result is loaded the
// block accepts new items while that result waits. A stalled receiver holds
// emission in place. Reset clears all sums and sets the register to 64; weights
// must be written before they are used.
module phase_shift_beamformer #(
  parameter int NUM_DIRS = psb_pkg::NumDirsDef,
  parameter int NUM_MICS = psb_pkg::NumMicsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Input item channel.
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  mode_i,
  input  logic [psb_pkg::DirFieldW-1:0]         direction_index_i,
  input  logic [psb_pkg::MicFieldW-1:0]         mic_index_i,
  input  logic signed [psb_pkg::WeightW-1:0]    weight_real_i,
  input  logic signed [psb_pkg::WeightW-1:0]    weight_imag_i,
  input  logic signed [psb_pkg::SampleW-1:0]    sample_value_i,
  input  logic                                  last_mic_i,
  // Result item channel.
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [psb_pkg::DirFieldW-1:0]         out_direction_o,
  output logic signed [psb_pkg::SumW-1:0]       sum_real_o,
  output logic signed [psb_pkg::SumW-1:0]       sum_imag_o,
  output logic                                  last_direction_o,
  // Configuration port.
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [psb_pkg::ApbAddrW-1:0]          paddr,
  input  logic [psb_pkg::ApbDataW-1:0]          pwdata,
  output logic [psb_pkg::ApbDataW-1:0]          prdata,
  output logic                                  pready
);
  import psb_pkg::*;

  localparam int DirW = (NUM_DIRS > 1) ? $clog2(NUM_DIRS) : 1;

  logic [CfgW-1:0] dirs_in_use_q;
  logic            reg_sel;
  psb_cmd_t        cmd;
  psb_status_t     status;
  logic [DirW-1:0] dir;

  // The register index is the word address; the byte offset is ignored.
  assign reg_sel = (paddr[2] == RegIdxDirs);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? ApbDataW'(dirs_in_use_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dirs_in_use_q <= CfgDirsRst;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      dirs_in_use_q <= pwdata[CfgW-1:0];
    end
  end

  psb_controller #(
    .NUM_DIRS (NUM_DIRS),
    .NUM_MICS (NUM_MICS)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .mode_i            (mode_i),
    .direction_index_i (direction_index_i),
    .mic_index_i       (mic_index_i),
    .last_mic_i        (last_mic_i),
    .dirs_in_use_i     (dirs_in_use_q),
    .status_i          (status),
    .cmd_o             (cmd),
    .dir_o             (dir)
  );

  psb_datapath #(
    .NUM_DIRS (NUM_DIRS),
    .NUM_MICS (NUM_MICS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .dir_i             (dir),
    .status_o          (status),
    .direction_index_i (direction_index_i),
    .mic_index_i       (mic_index_i),
    .weight_real_i     (weight_real_i),
    .weight_imag_i     (weight_imag_i),
    .sample_value_i    (sample_value_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .out_direction_o   (out_direction_o),
    .sum_real_o        (sum_real_o),
    .sum_imag_o        (sum_imag_o),
    .last_direction_o  (last_direction_o)
  );

endmodule
